[design/satl_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// satl_pkg
// Shared types and codes for the actuated traffic light controller.
// -----------------------------------------------------------------------------
package satl_pkg;

    localparam int TIME_W  = 32;
    localparam int DUR_W   = 20;
    localparam int CFG_A_W = 2;

    // Register reset values, ms
    localparam logic [DUR_W-1:0] YELLOW_TIME_RST   = 20'd3000;
    localparam logic [DUR_W-1:0] GREEN_TIMEOUT_RST = 20'd10000;
    localparam logic [DUR_W-1:0] MAX_WAIT_RST      = 20'd8000;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_YELLOW_TIME   = 2'd0,
        CFG_GREEN_TIMEOUT = 2'd1,
        CFG_MAX_WAIT      = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_VGREEN     = 3'd0,
        PH_V_TO_RED   = 3'd1,
        PH_V_FROM_RED = 3'd2,
        PH_HGREEN     = 3'd3,
        PH_H_TO_RED   = 3'd4,
        PH_H_FROM_RED = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        CLR_RED    = 2'd0,
        CLR_YELLOW = 2'd1,
        CLR_GREEN  = 2'd2
    } t_color;

    typedef struct packed {
        t_phase           phase_now;
        t_color           vert_color;
        t_color           horz_color;
        logic [DUR_W-1:0] green_left_vert;
        logic [DUR_W-1:0] green_left_horz;
        logic [DUR_W-1:0] red_left_vert;
        logic [DUR_W-1:0] red_left_horz;
    } t_result;

endpackage
`default_nettype wire

[design/satl_upd_if.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// satl_upd_if
// Update channel: timestamp and four car-presence bits.
// -----------------------------------------------------------------------------
interface satl_upd_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        car_lane1;
    logic        car_lane2;
    logic        car_lane3;
    logic        car_lane4;

    modport source (output valid, now_ms, car_lane1, car_lane2, car_lane3, car_lane4,
                    input ready);
    modport sink   (input valid, now_ms, car_lane1, car_lane2, car_lane3, car_lane4,
                    output ready);
endinterface
`default_nettype wire

[design/satl_res_if.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// satl_res_if
// Result channel: phase, light colors and remaining times.
// -----------------------------------------------------------------------------
interface satl_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase_now;
    logic [1:0]  vert_color;
    logic [1:0]  horz_color;
    logic [19:0] green_left_vert;
    logic [19:0] green_left_horz;
    logic [19:0] red_left_vert;
    logic [19:0] red_left_horz;

    modport source (output valid, phase_now, vert_color, horz_color, green_left_vert,
                    green_left_horz, red_left_vert, red_left_horz,
                    input ready);
    modport sink   (input valid, phase_now, vert_color, horz_color, green_left_vert,
                    green_left_horz, red_left_vert, red_left_horz,
                    output ready);
endinterface
`default_nettype wire

[design/satl_cfg_if.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// satl_cfg_if
// Register write channel: register index and write data.
// -----------------------------------------------------------------------------
interface satl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/sensor_actuated_traffic_light_fsm_core.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// sensor_actuated_traffic_light_fsm_core
// The result is registered: an update passes the input register, then the result
// register, which loads only while the result side is free.
// Throughput: one update per cycle while the result side takes results; the phase
// state advances as an update leaves the input register, so the next update sees it.
// Reset: phase vertical green, timers and stamps zero, registers to defaults.
// -----------------------------------------------------------------------------
module sensor_actuated_traffic_light_fsm_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    satl_upd_if.sink   i_upd,
    satl_cfg_if.sink   i_cfg,
    satl_res_if.source o_res
);
    import satl_pkg::*;

    // Configuration registers
    logic [DUR_W-1:0]  r_yellow_time;
    logic [DUR_W-1:0]  r_green_timeout;
    logic [DUR_W-1:0]  r_max_wait;

    // Input register
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_now;
    logic              r_in_vert;
    logic              r_in_horz;

    // Controller state
    t_phase            r_phase,       n_phase;
    logic [TIME_W-1:0] r_phase_start, n_phase_start;
    logic              r_fair,        n_fair;
    logic [TIME_W-1:0] r_fair_start,  n_fair_start;

    // Result register
    logic              r_out_valid;
    t_result           r_res,         n_res;

    logic              w_out_free;
    logic              w_adv;
    logic [TIME_W-1:0] w_el_phase;
    logic [TIME_W-1:0] w_el_fair;
    logic [TIME_W-1:0] w_el_phase_n;
    logic [TIME_W-1:0] w_el_fair_n;
    logic              w_mine;
    logic              w_other;
    logic              w_mine_n;
    logic              w_other_n;
    t_phase            w_green_next;
    logic [DUR_W-1:0]  w_wait_left;
    logic [DUR_W-1:0]  w_green_left;

    function automatic logic [DUR_W-1:0] left_of(logic [DUR_W-1:0]  limit,
                                                 logic [TIME_W-1:0] el);
        if (el >= {{(TIME_W-DUR_W){1'b0}}, limit}) begin
            return '0;
        end
        return limit - el[DUR_W-1:0];
    endfunction

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign i_upd.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yellow_time   <= YELLOW_TIME_RST;
            r_green_timeout <= GREEN_TIMEOUT_RST;
            r_max_wait      <= MAX_WAIT_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_YELLOW_TIME:   r_yellow_time   <= i_cfg.data;
                CFG_GREEN_TIMEOUT: r_green_timeout <= i_cfg.data;
                CFG_MAX_WAIT:      r_max_wait      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_upd.valid && i_upd.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (i_upd.valid && i_upd.ready) begin
            r_in_now  <= i_upd.now_ms;
            r_in_vert <= i_upd.car_lane1 | i_upd.car_lane3;
            r_in_horz <= i_upd.car_lane2 | i_upd.car_lane4;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_VGREEN;
            r_phase_start <= '0;
            r_fair        <= 1'b0;
            r_fair_start  <= '0;
        end else if (w_adv) begin
            r_phase       <= n_phase;
            r_phase_start <= n_phase_start;
            r_fair        <= n_fair;
            r_fair_start  <= n_fair_start;
        end
    end

    // Next state and result
    always_comb begin
        w_el_phase    = r_in_now - r_phase_start;
        w_el_fair     = r_in_now - r_fair_start;
        w_mine        = (r_phase == PH_VGREEN) ? r_in_vert : r_in_horz;
        w_other       = (r_phase == PH_VGREEN) ? r_in_horz : r_in_vert;
        w_green_next  = (r_phase == PH_VGREEN) ? PH_V_TO_RED : PH_H_TO_RED;
        n_phase       = r_phase;
        n_phase_start = r_phase_start;
        n_fair        = r_fair;
        n_fair_start  = r_fair_start;

        case (r_phase)
            PH_VGREEN, PH_HGREEN: begin
                if (w_other && !w_mine) begin
                    n_phase       = w_green_next;
                    n_phase_start = r_in_now;
                    n_fair        = 1'b0;
                end else if (w_mine && w_other) begin
                    if (!r_fair) begin
                        // both sides busy: start the fairness timer
                        n_fair       = 1'b1;
                        n_fair_start = r_in_now;
                    end else if (w_el_fair >= {{(TIME_W-DUR_W){1'b0}}, r_max_wait}) begin
                        n_phase       = w_green_next;
                        n_phase_start = r_in_now;
                        n_fair        = 1'b0;
                    end
                end else begin
                    if (!w_mine &&
                        w_el_phase >= {{(TIME_W-DUR_W){1'b0}}, r_green_timeout}) begin
                        n_phase       = w_green_next;
                        n_phase_start = r_in_now;
                    end
                    n_fair = 1'b0;
                end
            end
            PH_V_TO_RED, PH_H_TO_RED, PH_V_FROM_RED, PH_H_FROM_RED: begin
                if (w_el_phase >= {{(TIME_W-DUR_W){1'b0}}, r_yellow_time}) begin
                    n_phase_start = r_in_now;
                    case (r_phase)
                        PH_V_TO_RED:   n_phase = PH_H_FROM_RED;
                        PH_H_FROM_RED: n_phase = PH_HGREEN;
                        PH_H_TO_RED:   n_phase = PH_V_FROM_RED;
                        default:       n_phase = PH_VGREEN;
                    endcase
                end
            end
            default: begin
                n_phase       = PH_VGREEN;
                n_phase_start = r_in_now;
            end
        endcase

        // Result from the updated state
        w_el_phase_n = r_in_now - n_phase_start;
        w_el_fair_n  = r_in_now - n_fair_start;
        w_mine_n     = (n_phase == PH_VGREEN) ? r_in_vert : r_in_horz;
        w_other_n    = (n_phase == PH_VGREEN) ? r_in_horz : r_in_vert;
        w_wait_left  = n_fair ? left_of(r_max_wait, w_el_fair_n) : '0;

        if (w_mine_n && !w_other_n) begin
            w_green_left = r_green_timeout;
        end else if (w_mine_n && w_other_n && n_fair) begin
            w_green_left = left_of(r_max_wait, w_el_fair_n);
        end else if (!w_mine_n && !w_other_n) begin
            w_green_left = left_of(r_green_timeout, w_el_phase_n);
        end else begin
            w_green_left = '0;
        end

        n_res           = '0;
        n_res.phase_now = n_phase;
        case (n_phase) inside
            PH_VGREEN: begin
                n_res.vert_color = CLR_GREEN;
                n_res.horz_color = CLR_RED;
            end
            PH_V_TO_RED, PH_V_FROM_RED: begin
                n_res.vert_color = CLR_YELLOW;
                n_res.horz_color = CLR_RED;
            end
            PH_HGREEN: begin
                n_res.vert_color = CLR_RED;
                n_res.horz_color = CLR_GREEN;
            end
            default: begin
                n_res.vert_color = CLR_RED;
                n_res.horz_color = CLR_YELLOW;
            end
        endcase

        if (n_phase == PH_VGREEN) begin
            n_res.green_left_vert = w_green_left;
            n_res.red_left_horz   = w_wait_left;
        end else if (n_phase == PH_HGREEN) begin
            n_res.green_left_horz = w_green_left;
            n_res.red_left_vert   = w_wait_left;
        end
    end

    // Result stage: loads when empty or while the previous result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.phase_now       = r_res.phase_now;
    assign o_res.vert_color      = r_res.vert_color;
    assign o_res.horz_color      = r_res.horz_color;
    assign o_res.green_left_vert = r_res.green_left_vert;
    assign o_res.green_left_horz = r_res.green_left_horz;
    assign o_res.red_left_vert   = r_res.red_left_vert;
    assign o_res.red_left_horz   = r_res.red_left_horz;

`ifndef SYNTH
    // State moves only with a transfer out of the input register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !w_adv |=> $stable(r_phase) && $stable(r_fair) &&
                              $stable(r_phase_start) && $stable(r_fair_start))
        else $error("controller state changed without an update");

    // Fairness timer runs only during a green phase
    a_fair_in_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fair |-> (r_phase == PH_VGREEN) || (r_phase == PH_HGREEN))
        else $error("fairness timer running outside green");

    // Vertical green time left reported only during vertical green
    a_green_left_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.green_left_vert != '0) |-> r_res.phase_now == PH_VGREEN)
        else $error("vertical green time reported outside vertical green");

    // Forced red wait of the horizontal side mirrors the vertical fairness countdown
    a_red_wait_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.red_left_horz != '0) |->
            r_res.green_left_vert == r_res.red_left_horz)
        else $error("horizontal red wait disagrees with vertical green time");
`endif

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the actuated traffic light controller. Streams
// timestamped car-presence updates through several timing register settings
// and back-pressure patterns, predicts every result in a scoreboard and
// compares each returned result field by field.
// ----------------------------------------------------------------------------
module testbench;
    import satl_pkg::*;

    // Index with no register behind it; writes to it must be dropped
    localparam logic [CFG_A_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [DUR_W-1:0]   DUR_MAX       = '1;

    class light_scoreboard;
        logic [DUR_W-1:0]  yellow_ms;
        logic [DUR_W-1:0]  green_ms;
        logic [DUR_W-1:0]  wait_ms;
        t_phase            phase;
        logic [TIME_W-1:0] phase_t0;
        logic [TIME_W-1:0] fair_t0;
        bit                fair_on;
        t_result           lights_q[$];
        int unsigned       n_fail;
        int unsigned       n_checked;
        int unsigned       n_demand_sw;
        int unsigned       n_fair_sw;
        int unsigned       n_timeout_sw;
        bit [5:0]          phases_seen;

        function void clear();
            yellow_ms = YELLOW_TIME_RST;
            green_ms  = GREEN_TIMEOUT_RST;
            wait_ms   = MAX_WAIT_RST;
            phase     = PH_VGREEN;
            phase_t0  = '0;
            fair_t0   = '0;
            fair_on   = 1'b0;
            lights_q.delete();
        endfunction

        function void write_reg(logic [CFG_A_W-1:0] idx, logic [DUR_W-1:0] val);
            case (idx)
                CFG_YELLOW_TIME:   yellow_ms = val;
                CFG_GREEN_TIMEOUT: green_ms  = val;
                CFG_MAX_WAIT:      wait_ms   = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return lights_q.size();
        endfunction

        // Remaining ms of a limit, floored at zero; elapsed time wraps
        function logic [DUR_W-1:0] time_left(logic [DUR_W-1:0] limit,
                                             logic [TIME_W-1:0] since,
                                             logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] el;
            el = now - since;
            if (el >= {{(TIME_W-DUR_W){1'b0}}, limit}) return '0;
            return limit - el[DUR_W-1:0];
        endfunction

        function void advance_green(bit mine, bit other, logic [TIME_W-1:0] now,
                                    t_phase nxt);
            logic [TIME_W-1:0] el;
            if (other && !mine) begin
                phase    = nxt;
                phase_t0 = now;
                fair_on  = 1'b0;
                n_demand_sw++;
            end else if (mine && other) begin
                el = now - fair_t0;
                if (!fair_on) begin
                    fair_on = 1'b1;
                    fair_t0 = now;
                end else if (el >= {{(TIME_W-DUR_W){1'b0}}, wait_ms}) begin
                    phase    = nxt;
                    phase_t0 = now;
                    fair_on  = 1'b0;
                    n_fair_sw++;
                end
            end else begin
                el = now - phase_t0;
                if (!mine && el >= {{(TIME_W-DUR_W){1'b0}}, green_ms}) begin
                    phase    = nxt;
                    phase_t0 = now;
                    n_timeout_sw++;
                end
                fair_on = 1'b0;
            end
        endfunction

        function void advance_yellow(logic [TIME_W-1:0] now, t_phase nxt);
            logic [TIME_W-1:0] el;
            el = now - phase_t0;
            if (el >= {{(TIME_W-DUR_W){1'b0}}, yellow_ms}) begin
                phase    = nxt;
                phase_t0 = now;
            end
        endfunction

        function logic [DUR_W-1:0] green_left(bit mine, bit other, logic [TIME_W-1:0] now);
            if (mine && !other) return green_ms;
            if (mine && other && fair_on) return time_left(wait_ms, fair_t0, now);
            if (!mine && !other) return time_left(green_ms, phase_t0, now);
            return '0;
        endfunction

        // Advance the light state by one accepted update and queue its result
        function void note_update(logic [TIME_W-1:0] now, logic [3:0] lanes);
            bit      vert;
            bit      horz;
            t_result r;
            vert = lanes[0] | lanes[2];
            horz = lanes[1] | lanes[3];
            case (phase)
                PH_VGREEN:     advance_green(vert, horz, now, PH_V_TO_RED);
                PH_V_TO_RED:   advance_yellow(now, PH_H_FROM_RED);
                PH_H_FROM_RED: advance_yellow(now, PH_HGREEN);
                PH_HGREEN:     advance_green(horz, vert, now, PH_H_TO_RED);
                PH_H_TO_RED:   advance_yellow(now, PH_V_FROM_RED);
                PH_V_FROM_RED: advance_yellow(now, PH_VGREEN);
                default: begin
                    phase    = PH_VGREEN;
                    phase_t0 = now;
                end
            endcase

            r.phase_now       = phase;
            r.green_left_vert = '0;
            r.green_left_horz = '0;
            r.red_left_vert   = '0;
            r.red_left_horz   = '0;
            case (phase)
                PH_VGREEN: begin
                    r.vert_color = CLR_GREEN;
                    r.horz_color = CLR_RED;
                end
                PH_V_TO_RED, PH_V_FROM_RED: begin
                    r.vert_color = CLR_YELLOW;
                    r.horz_color = CLR_RED;
                end
                PH_HGREEN: begin
                    r.vert_color = CLR_RED;
                    r.horz_color = CLR_GREEN;
                end
                default: begin
                    r.vert_color = CLR_RED;
                    r.horz_color = CLR_YELLOW;
                end
            endcase

            if (phase == PH_VGREEN) begin
                r.green_left_vert = green_left(vert, horz, now);
                if (fair_on) r.red_left_horz = time_left(wait_ms, fair_t0, now);
            end else if (phase == PH_HGREEN) begin
                r.green_left_horz = green_left(horz, vert, now);
                if (fair_on) r.red_left_vert = time_left(wait_ms, fair_t0, now);
            end
            phases_seen[phase] = 1'b1;
            lights_q.push_back(r);
        endfunction

        function void field_cmp(string fld, logic [DUR_W-1:0] want, logic [DUR_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
                n_fail++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (lights_q.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual phase %0d",
                         $time, got.phase_now);
                n_fail++;
                return;
            end
            want = lights_q.pop_front();
            n_checked++;
            field_cmp("phase_now",       want.phase_now,       got.phase_now);
            field_cmp("vert_color",      want.vert_color,      got.vert_color);
            field_cmp("horz_color",      want.horz_color,      got.horz_color);
            field_cmp("green_left_vert", want.green_left_vert, got.green_left_vert);
            field_cmp("green_left_horz", want.green_left_horz, got.green_left_horz);
            field_cmp("red_left_vert",   want.red_left_vert,   got.red_left_vert);
            field_cmp("red_left_horz",   want.red_left_horz,   got.red_left_horz);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    satl_upd_if upd_if();
    satl_cfg_if cfg_if();
    satl_res_if res_if();

    sensor_actuated_traffic_light_fsm_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    light_scoreboard   lights = new();
    logic [TIME_W-1:0] clock_ms;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    int unsigned       hold_len;
    int unsigned       n_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout: %0d updates sent, %0d results still pending", n_sent,
                 lights.pending());
        $display("FAIL");
        $finish;
    end

    // Result sink: random stalls, plus long hold-offs requested by the stimulus
    initial begin : result_sink
        int unsigned n;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                n        = hold_len;
                hold_len = 0;
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.phase_now       = t_phase'(res_if.phase_now);
            got.vert_color      = t_color'(res_if.vert_color);
            got.horz_color      = t_color'(res_if.horz_color);
            got.green_left_vert = res_if.green_left_vert;
            got.green_left_horz = res_if.green_left_horz;
            got.red_left_vert   = res_if.red_left_vert;
            got.red_left_horz   = res_if.red_left_horz;
            lights.check_result(got);
        end
    end

    // Leaves valid high after the transfer so back-to-back updates need no gap
    task automatic send_update(input logic [TIME_W-1:0] now, input logic [3:0] lanes);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            upd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        upd_if.valid     <= 1'b1;
        upd_if.now_ms    <= now;
        upd_if.car_lane1 <= lanes[0];
        upd_if.car_lane2 <= lanes[1];
        upd_if.car_lane3 <= lanes[2];
        upd_if.car_lane4 <= lanes[3];
        @(posedge i_clk);
        while (!upd_if.ready) @(posedge i_clk);
        lights.note_update(now, lanes);
        n_sent++;
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [DUR_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        lights.write_reg(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has been returned, or the wait limit runs out
    task automatic settle();
        int unsigned waited;
        upd_if.valid <= 1'b0;
        waited = 0;
        while (lights.pending() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Demand held in runs so green phases see sustained traffic patterns
    task automatic random_updates(input int unsigned count);
        int unsigned span;
        int unsigned run_len;
        int unsigned demand;
        int unsigned pick;
        bit          want_v;
        bit          want_h;
        logic [1:0]  vpair;
        logic [1:0]  hpair;
        span = lights.yellow_ms;
        if (lights.green_ms > span) span = lights.green_ms;
        if (lights.wait_ms > span) span = lights.wait_ms;
        if (span == 0) span = 1;
        run_len = 0;
        demand  = 0;
        repeat (count) begin
            if (run_len == 0) begin
                run_len = $urandom_range(1, 8);
                demand  = $urandom_range(0, 9);
            end
            run_len--;
            case (demand)
                0, 1:    {want_v, want_h} = 2'b00;
                2, 3:    {want_v, want_h} = 2'b10;
                4, 5:    {want_v, want_h} = 2'b01;
                6, 7, 8: {want_v, want_h} = 2'b11;
                default: {want_v, want_h} = 2'($urandom_range(0, 3));
            endcase
            vpair = want_v ? 2'($urandom_range(1, 3)) : 2'b00;
            hpair = want_h ? 2'($urandom_range(1, 3)) : 2'b00;

            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // repeat the same timestamp
            end else if (pick < 75) begin
                clock_ms += $urandom_range(1, span / 4 + 1);
            end else if (pick < 95) begin
                clock_ms += $urandom_range(0, span + span / 2 + 1);
            end else begin
                clock_ms = $urandom();
            end
            send_update(clock_ms, {hpair[1], vpair[1], hpair[0], vpair[0]});
        end
    endtask

    task automatic run_phase(input logic [DUR_W-1:0] yellow, input logic [DUR_W-1:0] green,
                             input logic [DUR_W-1:0] wait_lim, input int unsigned send_pct,
                             input int unsigned stall_pct, input int unsigned count);
        settle();
        write_reg(CFG_YELLOW_TIME, yellow);
        write_reg(CFG_GREEN_TIMEOUT, green);
        write_reg(CFG_MAX_WAIT, wait_lim);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        clock_ms       = $urandom();
        random_updates(count);
    endtask

    initial begin : stimulus
        i_rst_n          = 1'b0;
        upd_if.valid     = 1'b0;
        upd_if.now_ms    = '0;
        upd_if.car_lane1 = 1'b0;
        upd_if.car_lane2 = 1'b0;
        upd_if.car_lane3 = 1'b0;
        upd_if.car_lane4 = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_YELLOW_TIME;
        cfg_if.data      = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_len         = 0;
        n_sent           = 0;
        clock_ms         = '0;
        lights.clear();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through every phase at the reset timings
        send_update(32'd0,     4'b0000);   // idle green, full timeout left
        send_update(32'd5000,  4'b0001);   // own side only busy
        send_update(32'd6000,  4'b0011);   // both busy: start fairness timer
        send_update(32'd10000, 4'b1100);   // fairness running, red wait counts down
        send_update(32'd14000, 4'b1111);   // max wait reached: forced switch
        send_update(32'd16999, 4'b0000);   // yellow one ms short
        send_update(32'd17000, 4'b0000);
        send_update(32'd20000, 4'b0000);   // horizontal green
        send_update(32'd20001, 4'b1010);   // own side only busy
        send_update(32'd20002, 4'b0101);   // other side only busy: switch at once
        send_update(32'd23002, 4'b0000);
        send_update(32'd26002, 4'b0000);   // back to vertical green
        send_update(32'd26003, 4'b0011);
        send_update(32'd26004, 4'b0000);   // demand gone: fairness dropped
        send_update(32'd36002, 4'b0000);   // green timeout
        send_update(32'hFFFF_FFFF, 4'b0000);
        send_update(32'd2999,  4'b0000);   // yellow elapsed across the wrap
        send_update(32'd3000,  4'b1111);
        send_update(32'd3000,  4'b1111);
        send_update(32'h8000_0000, 4'b1111);
        send_update(32'h8000_0000, 4'b0000);

        run_phase(20'd3, 20'd12, 20'd8, 0, 0, 60);
        run_phase('0, '0, '0, 86, 0, 60);
        run_phase(DUR_MAX, DUR_MAX, DUR_MAX, 0, 86, 60);
        run_phase(20'd7, 20'd30, 20'd18, 24, 24, 50);

        // Hold the result side off while updates keep coming, then drain fully
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 80;
        random_updates(30);
        settle();
        random_updates(20);

        run_phase(20'($urandom_range(1, 50)), 20'($urandom_range(1, 50)),
                  20'($urandom_range(1, 50)), 0, 0, 50);
        settle();
        write_reg(CFG_IDX_SPARE, 20'($urandom()));
        random_updates(30);

        run_phase(20'd1, DUR_MAX, 20'd5, 86, 0, 50);
        run_phase(20'($urandom()), 20'($urandom()), 20'($urandom()), 0, 86, 50);
        run_phase(20'd2, 20'd9, 20'd4, 24, 24, 60);

        settle();
        repeat (10) @(posedge i_clk);
        if (lights.pending() != 0) begin
            $display("%0t: %0d expected results never returned", $time, lights.pending());
            lights.n_fail += lights.pending();
        end
        $display("Covered %0d updates over 9 timing settings, %0d results compared",
                 n_sent, lights.n_checked);
        $display("Phases reached %b; switches on demand %0d, fairness %0d, timeout %0d",
                 lights.phases_seen, lights.n_demand_sw, lights.n_fair_sw,
                 lights.n_timeout_sw);
        if (lights.n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
